/* hdl/dcpm_pkg.sv */
// Shared constants and codes for the dwell-click pointer mapper.
// No dependencies; used by dwell_click_pointer_mapper.
`timescale 1ns / 1ps
`default_nettype none

package dcpm_pkg;

  // Default parameter values
  localparam int CAM_BITS_DEF   = 12;
  localparam int COUNT_BITS_DEF = 17;

  // Fixed field widths
  localparam int CMD_W     = 2;
  localparam int EDGE_W    = 12;
  localparam int SPAN_W    = 13;
  localparam int SIZE_W    = 14;
  localparam int RADIUS_W  = 12;
  localparam int TICKS_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int SCR_W     = 15;

  // Saturation limits of the mapped coordinate
  localparam logic [SCR_W-1:0] SCR_MAX   = 15'h3FFF;
  localparam logic [SCR_W-1:0] SCR_MIN   = 15'h4000;
  localparam int               SCR_POS_LIM = 16383;
  localparam int               SCR_NEG_LIM = 16384;

  // Register reset values
  localparam logic [EDGE_W-1:0]   RST_AREA_LEFT     = 12'd0;
  localparam logic [EDGE_W-1:0]   RST_AREA_TOP      = 12'd0;
  localparam logic [SPAN_W-1:0]   RST_AREA_WIDTH    = 13'd640;
  localparam logic [SPAN_W-1:0]   RST_AREA_HEIGHT   = 13'd480;
  localparam logic [SIZE_W-1:0]   RST_SCREEN_WIDTH  = 14'd1920;
  localparam logic [SIZE_W-1:0]   RST_SCREEN_HEIGHT = 14'd1080;
  localparam logic [RADIUS_W-1:0] RST_MOVE_RADIUS   = 12'd20;
  localparam logic [TICKS_W-1:0]  RST_DWELL_TICKS   = 16'd300;

  // Input commands; the fourth code is unused and ignored
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_TOGGLE = 2'd2
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_LEFT     = 3'd0,
    REG_AREA_TOP      = 3'd1,
    REG_AREA_WIDTH    = 3'd2,
    REG_AREA_HEIGHT   = 3'd3,
    REG_SCREEN_WIDTH  = 3'd4,
    REG_SCREEN_HEIGHT = 3'd5,
    REG_MOVE_RADIUS   = 3'd6,
    REG_DWELL_TICKS   = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

/* hdl/dwell_click_pointer_mapper.sv */
// Dwell-click pointer mapper: maps camera points to screen, issues dwell clicks.
// Tick and toggle items are taken while idle and leave the block idle and ready.
// A point item runs the one-bit-per-cycle restoring divider once per axis over MAG_W
// quotient bits (MAG_W = max(CAM_BITS,12)+14), then the distance test.
// One point at a time; the next item may enter while a result waits on the output.
// rst_ni is asynchronous, active low: registers to defaults, disabled, anchor/count zero.
`timescale 1ns / 1ps
`default_nettype none

module dwell_click_pointer_mapper #(
  parameter int CAM_BITS   = dcpm_pkg::CAM_BITS_DEF,
  parameter int COUNT_BITS = dcpm_pkg::COUNT_BITS_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  // configuration write port
  input  wire                             cfg_we_i,
  input  wire  [dcpm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [dcpm_pkg::CFG_W-1:0]      cfg_data_i,
  // input items
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [dcpm_pkg::CMD_W-1:0]      command_i,
  input  wire  [CAM_BITS-1:0]             cam_x_i,
  input  wire  [CAM_BITS-1:0]             cam_y_i,
  // result items
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic signed [dcpm_pkg::SCR_W-1:0] screen_x_o,
  output logic signed [dcpm_pkg::SCR_W-1:0] screen_y_o,
  output logic                            click_o
);

  // Widths
  // DM: magnitude of (cam - edge); MW: shared multiplier operand width
  localparam int DM     = (CAM_BITS > dcpm_pkg::EDGE_W) ? CAM_BITS : dcpm_pkg::EDGE_W;
  localparam int MW     = (DM > dcpm_pkg::SIZE_W) ? DM : dcpm_pkg::SIZE_W;
  localparam int PW     = 2 * MW;
  localparam int MAG_W  = DM + dcpm_pkg::SIZE_W;
  localparam int DCNT_W = $clog2(MAG_W + 1);
  localparam int CMP_W  = (COUNT_BITS > dcpm_pkg::TICKS_W) ? COUNT_BITS : dcpm_pkg::TICKS_W;
  localparam int SPW    = dcpm_pkg::SPAN_W;
  localparam int SCW    = dcpm_pkg::SCR_W;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Sequencer
  // PREP -> MUL -> DIV (MAG_W steps) -> SAT, once per axis, then the distance test
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL,
    ST_DIV,
    ST_SAT,
    ST_SQX,
    ST_SQY,
    ST_SQR,
    ST_DECIDE
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [dcpm_pkg::EDGE_W-1:0]   area_left_q, area_top_q;
  logic [SPW-1:0]                area_width_q, area_height_q;
  logic [dcpm_pkg::SIZE_W-1:0]   screen_width_q, screen_height_q;
  logic [dcpm_pkg::RADIUS_W-1:0] move_radius_q;
  logic [dcpm_pkg::TICKS_W-1:0]  dwell_ticks_q;

  // Block state
  logic                  enabled_q;
  logic [CAM_BITS-1:0]   anchor_x_q, anchor_y_q;
  logic [COUNT_BITS-1:0] dwell_count_q;

  // Control
  logic              axis_q;      // 0: x axis, 1: y axis
  logic [DCNT_W-1:0] div_cnt_q;

  // Output register
  logic           out_valid_q;
  logic [SCW-1:0] screen_x_q, screen_y_q;
  logic           click_q;

  // Datapath scratch
  logic [CAM_BITS-1:0] cam_x_q, cam_y_q;
  logic [CAM_BITS-1:0] dx_q, dy_q;
  logic [DM-1:0]       dmag_q;
  logic                neg_q;
  logic                mag_zero_q;
  logic [MAG_W-1:0]    quo_q;
  logic [SPW-1:0]      rem_q;
  logic [SCW-1:0]      sx_q, sy_q;
  logic [PW-1:0]       sq_q;
  logic [PW:0]         dist_q;
  logic [PW-1:0]       prod_q;

  // Handshakes
  logic in_acc, out_acc, dec_go;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_q && out_ready_i;
  assign dec_go      = (state_q == ST_DECIDE) && (!out_valid_q || out_ready_i);

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = screen_x_q;
  assign screen_y_o  = screen_y_q;
  assign click_o     = click_q;

  // Axis difference: |cam - edge| and its sign
  logic [CAM_BITS-1:0]         cam_sel;
  logic [dcpm_pkg::EDGE_W-1:0] edge_sel;
  logic [DM:0]                 diff;
  logic                        diff_neg;
  logic [DM-1:0]               diff_mag;
  logic [CAM_BITS-1:0]         dx_abs, dy_abs;

  always_comb begin
    cam_sel  = axis_q ? cam_y_q : cam_x_q;
    edge_sel = axis_q ? area_top_q : area_left_q;
    diff     = (DM + 1)'(cam_sel) - (DM + 1)'(edge_sel);
    diff_neg = diff[DM];
    diff_mag = diff_neg ? DM'((DM + 1)'(0) - diff) : diff[DM-1:0];
    dx_abs   = (cam_x_q >= anchor_x_q) ? (cam_x_q - anchor_x_q) : (anchor_x_q - cam_x_q);
    dy_abs   = (cam_y_q >= anchor_y_q) ? (cam_y_q - anchor_y_q) : (anchor_y_q - cam_y_q);
  end

  // Shared multiplier
  logic [MW-1:0]             mul_a, mul_b;
  logic [PW-1:0]             prod;
  logic [dcpm_pkg::SIZE_W-1:0] size_sel;

  always_comb begin
    size_sel = axis_q ? screen_height_q : screen_width_q;
    unique case (state_q)
      ST_MUL: begin
        mul_a = MW'(dmag_q);
        mul_b = MW'(size_sel);
      end
      ST_SQX: begin
        mul_a = MW'(dx_q);
        mul_b = MW'(dx_q);
      end
      ST_SQY: begin
        mul_a = MW'(dy_q);
        mul_b = MW'(dy_q);
      end
      ST_SQR: begin
        mul_a = MW'(move_radius_q);
        mul_b = MW'(move_radius_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = PW'(mul_a) * PW'(mul_b);
  end

  // Restoring divider step: one quotient bit a cycle
  logic [SPW-1:0] span_sel;
  logic [SPW:0]   trial;
  logic           trial_ge;
  logic [SPW-1:0] rem_next;

  always_comb begin
    span_sel = axis_q ? area_height_q : area_width_q;
    trial    = {rem_q, quo_q[MAG_W-1]};
    trial_ge = (trial >= {1'b0, span_sel});
    rem_next = trial_ge ? SPW'(trial - {1'b0, span_sel}) : trial[SPW-1:0];
  end

  // Saturation of the quotient; a zero divisor leaves all ones and saturates
  logic [SCW-1:0] sat_val;

  always_comb begin
    if (mag_zero_q) begin
      sat_val = '0;
    end else if (neg_q) begin
      sat_val = (quo_q > MAG_W'(dcpm_pkg::SCR_NEG_LIM)) ? dcpm_pkg::SCR_MIN
                                                        : SCW'(MAG_W'(0) - quo_q);
    end else begin
      sat_val = (quo_q > MAG_W'(dcpm_pkg::SCR_POS_LIM)) ? dcpm_pkg::SCR_MAX : SCW'(quo_q);
    end
  end

  // Distance test and dwell compare
  logic moved, dwell_done;

  assign moved      = (dist_q > (PW + 1)'(prod_q));
  assign dwell_done = (CMP_W'(dwell_count_q) > CMP_W'(dwell_ticks_q));

  // Control, configuration, block state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      area_left_q     <= dcpm_pkg::RST_AREA_LEFT;
      area_top_q      <= dcpm_pkg::RST_AREA_TOP;
      area_width_q    <= dcpm_pkg::RST_AREA_WIDTH;
      area_height_q   <= dcpm_pkg::RST_AREA_HEIGHT;
      screen_width_q  <= dcpm_pkg::RST_SCREEN_WIDTH;
      screen_height_q <= dcpm_pkg::RST_SCREEN_HEIGHT;
      move_radius_q   <= dcpm_pkg::RST_MOVE_RADIUS;
      dwell_ticks_q   <= dcpm_pkg::RST_DWELL_TICKS;
      enabled_q       <= 1'b0;
      anchor_x_q      <= '0;
      anchor_y_q      <= '0;
      dwell_count_q   <= '0;
      axis_q          <= 1'b0;
      div_cnt_q       <= '0;
      out_valid_q     <= 1'b0;
      screen_x_q      <= '0;
      screen_y_q      <= '0;
      click_q         <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (dcpm_pkg::reg_idx_e'(cfg_idx_i))
          dcpm_pkg::REG_AREA_LEFT:     area_left_q     <= cfg_data_i[dcpm_pkg::EDGE_W-1:0];
          dcpm_pkg::REG_AREA_TOP:      area_top_q      <= cfg_data_i[dcpm_pkg::EDGE_W-1:0];
          dcpm_pkg::REG_AREA_WIDTH:    area_width_q    <= cfg_data_i[SPW-1:0];
          dcpm_pkg::REG_AREA_HEIGHT:   area_height_q   <= cfg_data_i[SPW-1:0];
          dcpm_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[dcpm_pkg::SIZE_W-1:0];
          dcpm_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[dcpm_pkg::SIZE_W-1:0];
          dcpm_pkg::REG_MOVE_RADIUS:   move_radius_q   <= cfg_data_i[dcpm_pkg::RADIUS_W-1:0];
          dcpm_pkg::REG_DWELL_TICKS:   dwell_ticks_q   <= cfg_data_i[dcpm_pkg::TICKS_W-1:0];
          default: ;
        endcase
      end

      if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (dcpm_pkg::cmd_e'(command_i))
              dcpm_pkg::CMD_TICK: begin
                if (dwell_count_q != COUNT_MAX) begin
                  dwell_count_q <= dwell_count_q + 1'b1;
                end
              end
              dcpm_pkg::CMD_TOGGLE: enabled_q <= !enabled_q;
              dcpm_pkg::CMD_POINT: begin
                if (enabled_q) begin
                  axis_q  <= 1'b0;
                  state_q <= ST_PREP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PREP: state_q <= ST_MUL;
        ST_MUL: begin
          div_cnt_q <= DCNT_W'(MAG_W);
          state_q   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == DCNT_W'(1)) begin
            state_q <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (!axis_q) begin
            axis_q  <= 1'b1;
            state_q <= ST_PREP;
          end else begin
            state_q <= ST_SQX;
          end
        end
        ST_SQX: state_q <= ST_SQY;
        ST_SQY: state_q <= ST_SQR;
        ST_SQR: state_q <= ST_DECIDE;
        ST_DECIDE: begin
          // waits here while an earlier result is still held
          if (dec_go) begin
            out_valid_q <= 1'b1;
            screen_x_q  <= sx_q;
            screen_y_q  <= sy_q;
            if (moved) begin
              anchor_x_q    <= cam_x_q;
              anchor_y_q    <= cam_y_q;
              dwell_count_q <= '0;
              click_q       <= 1'b0;
            end else if (dwell_done) begin
              dwell_count_q <= '0;
              click_q       <= 1'b1;
            end else begin
              click_q <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath scratch registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cam_x_q <= cam_x_i;
      cam_y_q <= cam_y_i;
    end
    case (state_q)
      ST_PREP: begin
        dmag_q <= diff_mag;
        neg_q  <= diff_neg;
        dx_q   <= dx_abs;
        dy_q   <= dy_abs;
      end
      ST_MUL: begin
        quo_q      <= prod[MAG_W-1:0];
        rem_q      <= '0;
        mag_zero_q <= (dmag_q == '0) || (size_sel == '0);
      end
      ST_DIV: begin
        quo_q <= {quo_q[MAG_W-2:0], trial_ge};
        rem_q <= rem_next;
      end
      ST_SAT: begin
        if (axis_q) begin
          sy_q <= sat_val;
        end else begin
          sx_q <= sat_val;
        end
      end
      ST_SQX: sq_q <= prod;
      ST_SQY: prod_q <= prod;
      ST_SQR: begin
        dist_q <= (PW + 1)'(sq_q) + (PW + 1)'(prod_q);
        prod_q <= prod;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  // Point work only runs while enabled; toggles are taken only when idle
  a_busy_enabled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> enabled_q)
    else $error("point in progress while disabled");

  // Divider never runs with an exhausted step count
  a_div_cnt : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_cnt_q != '0))
    else $error("divider step count underflow");

  // Dwell counter saturates on a tick
  a_count_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == dcpm_pkg::CMD_TICK) && (dwell_count_q == COUNT_MAX))
    |=> (dwell_count_q == COUNT_MAX))
    else $error("dwell counter wrapped");

  // A fresh click always restarts the dwell
  a_click_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && click_q) |-> (dwell_count_q == '0))
    else $error("click issued without clearing dwell count");

  // Results come only from the decision step
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DECIDE))
    else $error("result raised outside decision step");
`endif

endmodule

`default_nettype wire
